FILE: rtl/mi3_pkg.sv
// Package for the 3x3 matrix inverse and determinant unit.
// Holds the fixed determinant width shared by the response interface, the top level and its checker.
// No dependencies.
package mi3_pkg;

   // The determinant result is always a 64-bit signed word.
   localparam int DET_OUT_WIDTH = 64;

endpackage

FILE: rtl/mi3_if.sv
// Valid/ready channel interfaces for the 3x3 matrix inverse unit: request and response.
// Depends on mi3_pkg for the determinant width.
interface mi3_req_if #(parameter int ELEM_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] a11;
   logic signed [ELEM_WIDTH-1:0] a21;
   logic signed [ELEM_WIDTH-1:0] a31;
   logic signed [ELEM_WIDTH-1:0] a12;
   logic signed [ELEM_WIDTH-1:0] a22;
   logic signed [ELEM_WIDTH-1:0] a32;
   logic signed [ELEM_WIDTH-1:0] a13;
   logic signed [ELEM_WIDTH-1:0] a23;
   logic signed [ELEM_WIDTH-1:0] a33;

   modport source (output valid, a11, a21, a31, a12, a22, a32, a13, a23, a33, input ready);
   modport sink   (input valid, a11, a21, a31, a12, a22, a32, a13, a23, a33, output ready);
endinterface

interface mi3_rsp_if #(parameter int ELEM_WIDTH = 32);
   import mi3_pkg::*;
   logic                            valid;
   logic                            ready;
   logic signed [ELEM_WIDTH-1:0]    inv11;
   logic signed [ELEM_WIDTH-1:0]    inv21;
   logic signed [ELEM_WIDTH-1:0]    inv31;
   logic signed [ELEM_WIDTH-1:0]    inv12;
   logic signed [ELEM_WIDTH-1:0]    inv22;
   logic signed [ELEM_WIDTH-1:0]    inv32;
   logic signed [ELEM_WIDTH-1:0]    inv13;
   logic signed [ELEM_WIDTH-1:0]    inv23;
   logic signed [ELEM_WIDTH-1:0]    inv33;
   logic signed [DET_OUT_WIDTH-1:0] determinant;
   logic                            singular;

   modport source (output valid, inv11, inv21, inv31, inv12, inv22, inv32, inv13, inv23,
                   inv33, determinant, singular, input ready);
   modport sink   (input valid, inv11, inv21, inv31, inv12, inv22, inv32, inv13, inv23,
                   inv33, determinant, singular, output ready);
endinterface

FILE: rtl/mi3_divider.sv
// Pipelined restoring divider with round-to-nearest input and signed saturation at the end.
// Used by the 3x3 matrix inverse top level; no package dependencies.
module mi3_divider #(
   parameter int ELEM_WIDTH = 32,
   parameter int NUM_WIDTH  = 99,
   parameter int DEN_WIDTH  = 100
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [NUM_WIDTH-1:0]  num,
   input  logic [DEN_WIDTH-1:0]  den,
   input  logic                  negative,
   output logic [ELEM_WIDTH-1:0] quotient
);

   localparam int QW    = ELEM_WIDTH + 1;
   localparam int RW    = ((NUM_WIDTH > DEN_WIDTH + QW) ? NUM_WIDTH : DEN_WIDTH + QW) + 1;
   localparam int STEPS = QW;

   logic [RW-1:0]        rem_ff  [0:STEPS];
   logic [DEN_WIDTH-1:0] den_ff  [0:STEPS];
   logic [QW-1:0]        q_ff    [0:STEPS];
   logic                 neg_ff  [0:STEPS];
   logic                 ovf_ff  [0:STEPS];
   logic                 ovf_in;
   logic                 big;
   logic [ELEM_WIDTH-1:0] quotient_in;
   logic [ELEM_WIDTH-1:0] quotient_ff;

   // A quotient that needs more than QW bits saturates regardless of the low bits.
   assign ovf_in = RW'(num) >= (RW'(den) << QW);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= RW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= negative;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      localparam int K = STEPS - s;
      logic [RW-1:0] shifted;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] q_in;

      always_comb begin
         shifted = RW'(den_ff[s-1]) << K;
         take    = rem_ff[s-1] >= shifted;
         rem_in  = take ? (rem_ff[s-1] - shifted) : rem_ff[s-1];
         q_in    = q_ff[s-1];
         q_in[K] = take;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_ff[s-1];
            q_ff[s]   <= q_in;
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   // A magnitude of 2^(ELEM_WIDTH-1) or more is out of range for a positive result and
   // lands exactly on (or beyond) the minimum for a negative one.
   always_comb begin
      big = ovf_ff[STEPS] | (|q_ff[STEPS][QW-1:QW-2]);
      if (big) begin
         quotient_in = neg_ff[STEPS] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      end else if (neg_ff[STEPS]) begin
         quotient_in = -q_ff[STEPS][ELEM_WIDTH-1:0];
      end else begin
         quotient_in = q_ff[STEPS][ELEM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

FILE: rtl/matrix3x3_inverse_determinant_unit.sv
// Top level of the 3x3 matrix inverse and determinant unit.
// Depends on mi3_pkg, the mi3_req_if / mi3_rsp_if channel interfaces and mi3_divider.

// This unit takes one 3x3 matrix of signed fixed-point elements per transfer and returns
// its determinant (rounded half up to twice the element fraction bits, saturated to
// 64 bits) together with the inverse, formed as the adjugate divided by the exact
// determinant, rounded to nearest with ties away from zero and saturated to the element
// width. A matrix whose exact determinant is zero is flagged singular and returns an
// all-zero inverse and a zero determinant. The unit is fully pipelined: a new matrix can
// be accepted on every clock cycle. Seven stages form the products, cofactors and
// determinant and prepare the operands; the rest of the pipeline is the nine restoring
// dividers, which resolve one quotient bit per stage. When the response side stalls,
// the whole pipeline holds, and the request side is ready whenever the output register
// is empty or its transfer completes in the same cycle.
module matrix3x3_inverse_determinant_unit #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   mi3_req_if.sink      req_if,
   mi3_rsp_if.source    rsp_if
);
   import mi3_pkg::*;

   localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
   localparam int COF_WIDTH   = 2 * ELEM_WIDTH + 1;
   localparam int PART_WIDTH  = 2 * ELEM_WIDTH + 1;
   localparam int TERM_WIDTH  = 3 * ELEM_WIDTH + 1;
   localparam int DET_WIDTH   = 3 * ELEM_WIDTH + 3;
   localparam int SAT_WIDTH   = (DET_WIDTH + 1 > DET_OUT_WIDTH + 1) ? DET_WIDTH + 1
                                                                     : DET_OUT_WIDTH + 1;
   localparam int NUM_SHIFT   = 2 * FRAC_BITS + 1;
   localparam int NUM_RAW     = COF_WIDTH + NUM_SHIFT;
   localparam int NUM_WIDTH   = ((NUM_RAW > DET_WIDTH) ? NUM_RAW : DET_WIDTH) + 1;
   localparam int DEN_WIDTH   = DET_WIDTH + 1;
   localparam int FRONT_DEPTH = 7;
   localparam int DIV_LATENCY = ELEM_WIDTH + 3;

   logic advance;

   // The whole pipeline moves together unless a finished result is waiting.
   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;

   logic [FRONT_DEPTH-1:0] valid_ff;
   logic [FRONT_DEPTH-1:0] valid_in;
   assign valid_in = {valid_ff[FRONT_DEPTH-2:0], req_if.valid};

   // Stage 1: the eighteen 2x2 minor products.
   logic signed [ELEM_WIDTH-1:0] m [3][3];
   logic signed [PROD_WIDTH-1:0] pa_in [3][3];
   logic signed [PROD_WIDTH-1:0] pb_in [3][3];
   logic signed [PROD_WIDTH-1:0] pa_ff [3][3];
   logic signed [PROD_WIDTH-1:0] pb_ff [3][3];
   logic signed [ELEM_WIDTH-1:0] col1_ff [3];

   assign m[0][0] = req_if.a11;
   assign m[1][0] = req_if.a21;
   assign m[2][0] = req_if.a31;
   assign m[0][1] = req_if.a12;
   assign m[1][1] = req_if.a22;
   assign m[2][1] = req_if.a32;
   assign m[0][2] = req_if.a13;
   assign m[1][2] = req_if.a23;
   assign m[2][2] = req_if.a33;

   always_comb begin
      int r1, r2, c1, c2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            c1 = (c == 0) ? 1 : 0;
            c2 = (c == 2) ? 1 : 2;
            pa_in[r][c] = m[r1][c1] * m[r2][c2];
            pb_in[r][c] = m[r1][c2] * m[r2][c1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         for (int r = 0; r < 3; r++) begin
            col1_ff[r] <= m[r][0];
         end
      end
   end

   // Stage 2: signed cofactors.
   logic signed [COF_WIDTH-1:0]  cof2_in [3][3];
   logic signed [COF_WIDTH-1:0]  cof2_ff [3][3];
   logic signed [ELEM_WIDTH-1:0] col2_ff [3];

   always_comb begin
      logic signed [COF_WIDTH-1:0] diff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            diff = COF_WIDTH'(pa_ff[r][c]) - COF_WIDTH'(pb_ff[r][c]);
            cof2_in[r][c] = (((r + c) & 1) != 0) ? -diff : diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cof2_ff <= cof2_in;
         col2_ff <= col1_ff;
      end
   end

   // Stage 3: each first-column term is split into two narrow partial products.
   logic signed [PART_WIDTH-1:0] plo_in [3];
   logic signed [PART_WIDTH-1:0] phi_in [3];
   logic signed [PART_WIDTH-1:0] plo_ff [3];
   logic signed [PART_WIDTH-1:0] phi_ff [3];
   logic signed [COF_WIDTH-1:0]  cof3_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         plo_in[r] = col2_ff[r] * $signed({1'b0, cof2_ff[r][0][ELEM_WIDTH-1:0]});
         phi_in[r] = col2_ff[r] * $signed(cof2_ff[r][0][COF_WIDTH-1:ELEM_WIDTH]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         cof3_ff <= cof2_ff;
      end
   end

   // Stage 4: recombine the partial products into exact row terms.
   logic signed [TERM_WIDTH-1:0] term_in [3];
   logic signed [TERM_WIDTH-1:0] term_ff [3];
   logic signed [COF_WIDTH-1:0]  cof4_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         term_in[r] = TERM_WIDTH'(plo_ff[r]) + (TERM_WIDTH'(phi_ff[r]) <<< ELEM_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term_ff <= term_in;
         cof4_ff <= cof3_ff;
      end
   end

   // Stage 5: exact determinant, and cofactor magnitudes in adjugate (transposed) order.
   logic signed [DET_WIDTH-1:0] det5_in;
   logic signed [DET_WIDTH-1:0] det5_ff;
   logic [COF_WIDTH-1:0]        nmag5_in [3][3];
   logic                        nneg5_in [3][3];
   logic [COF_WIDTH-1:0]        nmag5_ff [3][3];
   logic                        nneg5_ff [3][3];

   always_comb begin
      det5_in = DET_WIDTH'(term_ff[0]) + DET_WIDTH'(term_ff[1]) + DET_WIDTH'(term_ff[2]);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            nneg5_in[r][c] = cof4_ff[c][r][COF_WIDTH-1];
            nmag5_in[r][c] = nneg5_in[r][c] ? -cof4_ff[c][r] : cof4_ff[c][r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         det5_ff  <= det5_in;
         nmag5_ff <= nmag5_in;
         nneg5_ff <= nneg5_in;
      end
   end

   // Stage 6: determinant magnitude, zero test and the rounded determinant.
   logic [DET_WIDTH-1:0]          dmag6_in;
   logic [DET_WIDTH-1:0]          dmag6_ff;
   logic                          dneg6_ff;
   logic                          zero6_ff;
   logic signed [DET_WIDTH:0]     det_half;
   logic signed [SAT_WIDTH-1:0]   rnd6_in;
   logic signed [SAT_WIDTH-1:0]   rnd6_ff;
   logic [COF_WIDTH-1:0]          nmag6_ff [3][3];
   logic                          nneg6_ff [3][3];

   always_comb begin
      dmag6_in = det5_ff[DET_WIDTH-1] ? -det5_ff : det5_ff;
      det_half = (DET_WIDTH+1)'(det5_ff) + ((DET_WIDTH+1)'(1) <<< (FRAC_BITS - 1));
      rnd6_in  = SAT_WIDTH'(det_half >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dmag6_ff <= dmag6_in;
         dneg6_ff <= det5_ff[DET_WIDTH-1];
         zero6_ff <= (det5_ff == '0);
         rnd6_ff  <= rnd6_in;
         nmag6_ff <= nmag5_ff;
         nneg6_ff <= nneg5_ff;
      end
   end

   // Stage 7: divider operands. Rounding to nearest is folded into the numerator as
   // (2n + d) / 2d; the determinant saturates to 64 bits.
   logic [NUM_WIDTH-1:0]         num7_in [3][3];
   logic [NUM_WIDTH-1:0]         num7_ff [3][3];
   logic                         neg7_ff [3][3];
   logic [DEN_WIDTH-1:0]         den7_ff;
   logic                         sing7_ff;
   logic [SAT_WIDTH-DET_OUT_WIDTH:0] rnd_high;
   logic signed [DET_OUT_WIDTH-1:0]  det7_in;
   logic signed [DET_OUT_WIDTH-1:0]  det7_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            num7_in[r][c] = (NUM_WIDTH'(nmag6_ff[r][c]) << NUM_SHIFT) + NUM_WIDTH'(dmag6_ff);
         end
      end
      rnd_high = rnd6_ff[SAT_WIDTH-1:DET_OUT_WIDTH-1];
      if ((&rnd_high) || !(|rnd_high)) begin
         det7_in = rnd6_ff[DET_OUT_WIDTH-1:0];
      end else if (rnd6_ff[SAT_WIDTH-1]) begin
         det7_in = {1'b1, {(DET_OUT_WIDTH-1){1'b0}}};
      end else begin
         det7_in = {1'b0, {(DET_OUT_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num7_ff  <= num7_in;
         den7_ff  <= {dmag6_ff, 1'b0};
         sing7_ff <= zero6_ff;
         det7_ff  <= det7_in;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               neg7_ff[r][c] <= nneg6_ff[r][c] ^ dneg6_ff;
            end
         end
      end
   end

   // Nine dividers, one per inverse element, all sharing the stall.
   logic [ELEM_WIDTH-1:0] quot [3][3];

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         mi3_divider #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .NUM_WIDTH  (NUM_WIDTH),
            .DEN_WIDTH  (DEN_WIDTH)
         ) u_div (
            .clock    (clock),
            .enable   (advance),
            .num      (num7_ff[r][c]),
            .den      (den7_ff),
            .negative (neg7_ff[r][c]),
            .quotient (quot[r][c])
         );
      end
   end

   // Side band that runs alongside the dividers.
   logic [DIV_LATENCY-1:0]          side_valid_ff;
   logic                            side_sing_ff [DIV_LATENCY];
   logic signed [DET_OUT_WIDTH-1:0] side_det_ff  [DIV_LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         side_valid_ff <= '0;
      end else if (advance) begin
         valid_ff      <= valid_in;
         side_valid_ff <= {side_valid_ff[DIV_LATENCY-2:0], valid_ff[FRONT_DEPTH-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_sing_ff[0] <= sing7_ff;
         side_det_ff[0]  <= det7_ff;
         for (int i = 1; i < DIV_LATENCY; i++) begin
            side_sing_ff[i] <= side_sing_ff[i-1];
            side_det_ff[i]  <= side_det_ff[i-1];
         end
      end
   end

   logic out_sing;
   assign out_sing = side_sing_ff[DIV_LATENCY-1];

   assign rsp_if.valid       = side_valid_ff[DIV_LATENCY-1];
   assign rsp_if.singular    = out_sing;
   assign rsp_if.determinant = side_det_ff[DIV_LATENCY-1];
   assign rsp_if.inv11       = out_sing ? '0 : quot[0][0];
   assign rsp_if.inv21       = out_sing ? '0 : quot[1][0];
   assign rsp_if.inv31       = out_sing ? '0 : quot[2][0];
   assign rsp_if.inv12       = out_sing ? '0 : quot[0][1];
   assign rsp_if.inv22       = out_sing ? '0 : quot[1][1];
   assign rsp_if.inv32       = out_sing ? '0 : quot[2][1];
   assign rsp_if.inv13       = out_sing ? '0 : quot[0][2];
   assign rsp_if.inv23       = out_sing ? '0 : quot[1][2];
   assign rsp_if.inv33       = out_sing ? '0 : quot[2][2];

endmodule

FILE: rtl/mi3_checker.sv
// Port-level assertions for the 3x3 matrix inverse unit, bound to its top level.
// Depends on mi3_pkg and on matrix3x3_inverse_determinant_unit.
module mi3_checker #(parameter int ELEM_WIDTH = 32) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mi3_pkg::DET_OUT_WIDTH-1:0] determinant,
   input logic                             singular,
   input logic [ELEM_WIDTH-1:0]            inv11,
   input logic [ELEM_WIDTH-1:0]            inv21,
   input logic [ELEM_WIDTH-1:0]            inv31,
   input logic [ELEM_WIDTH-1:0]            inv12,
   input logic [ELEM_WIDTH-1:0]            inv22,
   input logic [ELEM_WIDTH-1:0]            inv32,
   input logic [ELEM_WIDTH-1:0]            inv13,
   input logic [ELEM_WIDTH-1:0]            inv23,
   input logic [ELEM_WIDTH-1:0]            inv33
);
   import mi3_pkg::*;

   // A singular result carries a zero determinant and an all-zero inverse.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && singular) |-> (determinant == '0 && inv11 == '0 && inv21 == '0 &&
         inv31 == '0 && inv12 == '0 && inv22 == '0 && inv32 == '0 && inv13 == '0 &&
         inv23 == '0 && inv33 == '0))
      else $error("singular result with nonzero fields");

   // The input side only waits while a result is held back.
   a_ready_unless_stalled: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !rsp_ready) |-> req_ready)
      else $error("input not ready while output is free");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays offered.
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its determinant, singular flag and diagonal inverse elements.
   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(determinant) && $stable(singular) &&
         $stable(inv11) && $stable(inv22) && $stable(inv33)))
      else $error("result changed while stalled");

endmodule

bind matrix3x3_inverse_determinant_unit mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .determinant (rsp_if.determinant),
   .singular    (rsp_if.singular),
   .inv11       (rsp_if.inv11),
   .inv21       (rsp_if.inv21),
   .inv31       (rsp_if.inv31),
   .inv12       (rsp_if.inv12),
   .inv22       (rsp_if.inv22),
   .inv32       (rsp_if.inv32),
   .inv13       (rsp_if.inv13),
   .inv23       (rsp_if.inv23),
   .inv33       (rsp_if.inv33)
);
